// ===== hw/rtl/ph80_pkg.sv =====
package ph80_pkg;

  localparam int ROUND_COUNT = 12;
  localparam int CELL_COUNT  = 25;
  localparam int STATE_W     = 4 * CELL_COUNT;

  typedef logic [STATE_W-1:0] ph80_state_t;

  typedef struct packed {
    logic [35:0] state_high_in;
    logic [63:0] state_low_in;
  } ph80_in_t;

  typedef struct packed {
    logic [35:0] state_high_out;
    logic [63:0] state_low_out;
  } ph80_out_t;

  typedef logic [3:0] nib_t;

  localparam nib_t SBOX_TAB [16] = '{
    4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
    4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2
  };

  localparam nib_t RC_TAB [12] = '{
    4'd1, 4'd3, 4'd7, 4'd14, 4'd13, 4'd11, 4'd6, 4'd12, 4'd9, 4'd2, 4'd5, 4'd10
  };

  localparam nib_t IC_TAB [5] = '{4'd0, 4'd1, 4'd3, 4'd6, 4'd4};

  localparam nib_t MIX_TAB [5][5] = '{
    '{4'd1,  4'd2,  4'd9,  4'd9,  4'd2},
    '{4'd2,  4'd5,  4'd3,  4'd8,  4'd13},
    '{4'd13, 4'd11, 4'd10, 4'd12, 4'd1},
    '{4'd1,  4'd15, 4'd2,  4'd3,  4'd14},
    '{4'd14, 4'd14, 4'd8,  4'd5,  4'd12}
  };

  // multiply in gf(16) modulo x^4 + x + 1
  function automatic nib_t gf16_mul(input nib_t a, input nib_t b);
    nib_t acc;
    nib_t x;
    acc = '0;
    x   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ x;
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return acc;
  endfunction

  // one full round: add constant, s-box, row rotate, column mix
  function automatic ph80_state_t ph80_round(input ph80_state_t s, input nib_t rc);
    nib_t        a   [5][5];
    nib_t        t   [5][5];
    nib_t        acc;
    ph80_state_t res;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        a[i][j] = s[STATE_W-1-4*(5*i+j) -: 4];
      end
      a[i][0] = a[i][0] ^ rc ^ IC_TAB[i];
    end
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        t[i][j] = SBOX_TAB[a[i][(j+i)%5]];
      end
    end
    res = '0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        acc = '0;
        for (int k = 0; k < 5; k++) begin
          acc = acc ^ gf16_mul(MIX_TAB[i][k], t[k][j]);
        end
        res[STATE_W-1-4*(5*i+j) -: 4] = acc;
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ph80_round_stage.sv =====
module ph80_round_stage
  import ph80_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  input  ph80_state_t state_i,
  input  nib_t        rc_i,
  output logic        valid_o,
  output ph80_state_t state_o
);

  logic        valid_r;
  ph80_state_t state_r;
  ph80_state_t state_nxt;

  assign state_nxt = ph80_round(state_i, rc_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (valid_i) begin
      state_r <= state_nxt;
    end
  end

  assign valid_o = valid_r;
  assign state_o = state_r;

endmodule

// ===== hw/rtl/photon80_permutation_top.sv =====
// channel | ports                        | handshake
// input   | start, busy, in_req          | taken when start && !busy
// result  | out_valid, out_res           | one-cycle strobe, no back-pressure
//
// one round per pipeline stage, ROUND_COUNT stages, each closed by a register
// a new request may enter every cycle while busy is low, one result per request in order
// synchronous active-low reset clears the stage valid bits; busy is a register
// that reset sets and that clears once reset is released, then stays low
// the receiver cannot stall, so the pipe never holds and never drops a request
module photon80_permutation_top
  import ph80_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ph80_in_t  in_req,
  output logic      out_valid,
  output ph80_out_t out_res
);

  // busy only while coming out of reset
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // stage chain: index 0 is the entry, index ROUND_COUNT the last register
  logic        vld   [ROUND_COUNT+1];
  ph80_state_t st    [ROUND_COUNT+1];

  assign vld[0] = start && !busy_r;
  assign st[0]  = {in_req.state_high_in, in_req.state_low_in};

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    // round constant is fixed per stage
    ph80_round_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld[g]),
      .state_i (st[g]),
      .rc_i    (RC_TAB[g % 12]),
      .valid_o (vld[g+1]),
      .state_o (st[g+1])
    );
  end

  // result strobe straight off the last stage register
  assign out_valid              = vld[ROUND_COUNT];
  assign out_res.state_high_out = st[ROUND_COUNT][STATE_W-1 -: 36];
  assign out_res.state_low_out  = st[ROUND_COUNT][63:0];

endmodule
